### src/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; imported by ple_rem and positional_list_engine.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int unsigned REQ_W    = 2;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned FIDX_W   = 4;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 16;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam req_t REQ_INSERT = 2'd0;
	localparam req_t REQ_REMOVE = 2'd1;
	localparam req_t REQ_SEARCH = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_MISS  = 2'd3;

endpackage

### src/ple_rem.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
// Depends on ple_pkg for the dividend width.
`timescale 1ns / 1ps

module ple_rem #(
	parameter int unsigned LenW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ple_pkg::POS_W-1:0]  dividend,
	input  logic [LenW-1:0]            divisor,
	output logic                       done,
	output logic [LenW-1:0]            rem
);
	import ple_pkg::*;

	localparam int unsigned CntW = $clog2(POS_W);

	logic            active_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [POS_W-1:0] shift_q;
	logic [LenW-1:0] div_q;
	logic [LenW-1:0] acc_q;
	logic [LenW:0]   trial;
	logic [LenW:0]   diff;

	always_comb begin
		trial = {acc_q, shift_q[POS_W-1]};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(POS_W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			acc_q   <= '0;
		end else if (active_q) begin
			shift_q <= {shift_q[POS_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				acc_q <= diff[LenW-1:0];
			else
				acc_q <= trial[LenW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = acc_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !active_q)
		else $error("remainder done while still active");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> (acc_q < div_q))
		else $error("remainder not below divisor");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("remainder done longer than one cycle");

endmodule

### src/positional_list_engine.sv
// Top level of the positional list engine: list store, sequencer, stream ports.
// Depends on ple_pkg and ple_rem.
`timescale 1ns / 1ps

// Usage:
// Input words arrive on s_tvalid/s_tready; s_tuser carries the request kind
// (insert, remove, search), s_tdata the position and the value. Each word
// yields one result word on m_tvalid/m_tready with the status in m_tuser and
// found index and entry count in m_tdata.
// The list lives in a single-port-write, registered-read memory of CAPACITY
// entries; one shared read/compare path walks it one entry at a time.
// Per word: insert moves the entries from the end down to the insert point up
// by one, then writes the value; a nonzero position into a nonempty list first
// takes the wrap step (bit-serial remainder, one bit per cycle over 8 bits).
// Remove shifts the entries above the removed one down by one; search compares
// from index 0 until a hit or the end of the list (a miss). Empty or full
// cases and unknown kinds go straight to the result.
// s_tready is high only while the sequencer is idle, so one word is in work
// at a time; a finished result waits in the output register and the next
// word may be taken meanwhile, but its result holds until the first leaves.
// Reset clears the entry count and the control state; memory contents are
// left as they are, and their contents are never used before written.

module positional_list_engine #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] position, [39:8] value
	input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [ple_pkg::REQ_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] found_index, [8:4] entry_count, [15:9] zero
	output logic [ple_pkg::M_DATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [ple_pkg::STAT_W-1:0]    m_tuser
);
	import ple_pkg::*;

	localparam int unsigned LenW = $clog2(CAPACITY + 1);
	localparam int unsigned IdxW = $clog2(CAPACITY);
	localparam int unsigned CmpW = (LenW > POS_W) ? LenW : POS_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_INS_RD,
		S_INS_WR,
		S_REM_RD,
		S_REM_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [LenW-1:0]   len_q;
	logic [LenW-1:0]   ptr_q;
	logic [IdxW-1:0]   at_q;
	logic [VAL_W-1:0]  value_q;
	status_t           status_q;
	logic [FIDX_W-1:0] found_q;
	logic              m_tvalid_q;
	status_t           m_status_q;
	logic [FIDX_W-1:0] m_found_q;
	logic [CNT_W-1:0]  m_count_q;

	logic [VAL_W-1:0]  mem [CAPACITY];
	logic [VAL_W-1:0]  rd_q;
	logic [IdxW-1:0]   mem_raddr;
	logic [IdxW-1:0]   mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;
	logic              mem_we;

	logic              s_fire;
	req_t              in_req;
	logic [POS_W-1:0]  in_pos;
	logic [VAL_W-1:0]  in_val;
	logic              rem_start;
	logic              rem_done;
	logic [LenW-1:0]   rem_val;
	logic              ins_put;

	assign s_fire   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign in_req   = s_tuser;
	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_val   = s_tdata[POS_W +: VAL_W];
	assign rem_start = s_fire && (in_req == REQ_INSERT) && (len_q < LenW'(CAPACITY))
		&& (len_q != '0) && (in_pos != '0);
	assign ins_put  = (state_q == S_INS_RD) && (ptr_q == LenW'(at_q));

	ple_rem #(.LenW(LenW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (in_pos - POS_W'(1)),
		.divisor  (len_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	always_comb begin
		logic [LenW-1:0] dn;
		logic [LenW-1:0] up;
		dn        = ptr_q - LenW'(1);
		up        = ptr_q + LenW'(1);
		mem_raddr = ptr_q[IdxW-1:0];
		mem_waddr = ptr_q[IdxW-1:0];
		mem_wdata = rd_q;
		mem_we    = 1'b0;
		unique case (state_q)
			S_INS_RD: begin
				mem_raddr = dn[IdxW-1:0];
				if (ins_put) begin
					mem_we    = 1'b1;
					mem_waddr = at_q;
					mem_wdata = value_q;
				end
			end
			S_INS_WR: mem_we = 1'b1;
			S_REM_RD: mem_raddr = up[IdxW-1:0];
			S_REM_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						value_q  <= in_val;
						status_q <= ST_OK;
						found_q  <= '0;
						ptr_q    <= len_q;
						at_q     <= '0;
						state_q  <= S_DONE;
						case (in_req)
							REQ_INSERT: begin
								if (len_q >= LenW'(CAPACITY))
									status_q <= ST_FULL;
								else if (rem_start)
									state_q <= S_MOD;
								else
									state_q <= S_INS_RD;
							end
							REQ_REMOVE: begin
								if (len_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_REM_RD;
									if (CmpW'(in_pos) < CmpW'(len_q)) begin
										ptr_q <= LenW'(in_pos);
									end else begin
										ptr_q <= '0;
									end
								end
							end
							REQ_SEARCH: begin
								ptr_q <= '0;
								if (len_q == '0)
									status_q <= ST_EMPTY;
								else
									state_q <= S_SRCH_RD;
							end
							default: ;
						endcase
					end
				end
				S_MOD: begin
					if (rem_done) begin
						at_q    <= IdxW'(rem_val + LenW'(1));
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (ins_put) begin
						len_q   <= len_q + LenW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					ptr_q   <= ptr_q - LenW'(1);
					state_q <= S_INS_RD;
				end
				S_REM_RD: begin
					if ((ptr_q + LenW'(1)) < len_q) begin
						state_q <= S_REM_WR;
					end else begin
						len_q   <= len_q - LenW'(1);
						state_q <= S_DONE;
					end
				end
				S_REM_WR: begin
					ptr_q   <= ptr_q + LenW'(1);
					state_q <= S_REM_RD;
				end
				S_SRCH_RD: begin
					if (ptr_q < len_q) begin
						state_q <= S_SRCH_CMP;
					end else begin
						status_q <= ST_MISS;
						state_q  <= S_DONE;
					end
				end
				S_SRCH_CMP: begin
					if (rd_q == value_q) begin
						found_q <= FIDX_W'(ptr_q);
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + LenW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= status_q;
						m_found_q  <= found_q;
						m_count_q  <= CNT_W'(len_q);
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(M_DATA_W - FIDX_W - CNT_W){1'b0}}, m_count_q, m_found_q};

	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LenW'(CAPACITY))
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != $past(len_q)) |-> ($past(state_q) == S_INS_RD || $past(state_q) == S_REM_RD))
		else $error("entry count changed outside insert or remove");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && in_req == REQ_INSERT && len_q == LenW'(CAPACITY)) |=> $stable(len_q))
		else $error("insert into full list changed the count");
	assert property (@(posedge clk) disable iff (!arst_n) rem_done |-> (state_q == S_MOD))
		else $error("remainder finished outside the wrap step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_RD && !ins_put) |-> (ptr_q > LenW'(at_q)))
		else $error("insert shift pointer passed the insert point");

endmodule
